// File: hw/rtl/learnable_remote_key_command_mapper_unit_macros.svh
// Assertion macros shared by the mapper checker.
`ifndef LEARNABLE_REMOTE_KEY_COMMAND_MAPPER_UNIT_MACROS_SVH
`define LEARNABLE_REMOTE_KEY_COMMAND_MAPPER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LRKCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lrkcm check failed");

// Next-cycle implication, checked out of reset.
`define LRKCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lrkcm check failed");

`endif

// File: hw/rtl/lrkcm_pkg.sv
// Types and constants of the learnable remote key command mapper.
`default_nettype none

package lrkcm_pkg;

    localparam int NUM_KEYS = 10;
    localparam int IDX_W    = $clog2(NUM_KEYS);
    localparam int SLOT_W   = $clog2(NUM_KEYS + 1);

    localparam logic [15:0] LEARN_TIMEOUT_RST = 16'd10000;
    localparam logic [6:0]  SPEED_STEP_RST    = 7'd10;
    localparam logic [7:0]  LEFT_SPEED_RST    = 8'd210;
    localparam logic [7:0]  RIGHT_SPEED_RST   = 8'd200;
    localparam logic [3:0]  BEEPS_MAX         = 4'd15;

    localparam int          ADDR_W       = 3;
    localparam logic        REG_TIMEOUT  = 1'b0;
    localparam logic        REG_STEP     = 1'b1;

    typedef enum logic [1:0] {
        MODE_LEARN  = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_AVOID  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        MOTOR_NONE  = 2'd0,
        MOTOR_DRIVE = 2'd1,
        MOTOR_SPEED = 2'd2
    } t_motor_cmd;

    typedef enum logic [3:0] {
        KEY_STOP     = 4'd0,
        KEY_FORWARD  = 4'd1,
        KEY_BACKWARD = 4'd2,
        KEY_LEFT     = 4'd3,
        KEY_RIGHT    = 4'd4,
        KEY_FASTER   = 4'd5,
        KEY_SLOWER   = 4'd6,
        KEY_BEEP     = 4'd7,
        KEY_AVOID    = 4'd8,
        KEY_NONE     = 4'd15
    } t_key_act;

    localparam int KEY_ACTIONS = 9;

endpackage

`default_nettype wire

// File: hw/rtl/learnable_remote_key_command_mapper_unit.sv
// Top level of the learnable remote key command mapper.
`default_nettype none

// One result beat per input beat. A beat is taken in every cycle unless the
// output register holds a result that is stalled; its result shows in the
// next cycle. All work (config pin handling, the priority compare of the
// code against all key slots, the speed update and the learn timer) is one
// combinational pass from the accepted beat and the state registers into the
// state and the output register. The key table sits in flip-flops and is
// cleared by reset. The output register carries no skid: o_stall follows
// i_stall only while a result is held.
module learnable_remote_key_command_mapper_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [lrkcm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_config_pin,
    input  wire logic        i_code_valid,
    input  wire logic [31:0] i_key_code,
    input  wire logic [31:0] i_now_ms,

    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [1:0]  o_mode,
    output logic      [1:0]  o_motor_cmd,
    output logic             o_left_forward,
    output logic      [7:0]  o_left_speed,
    output logic             o_right_forward,
    output logic      [7:0]  o_right_speed,
    output logic             o_entry_beep,
    output logic             o_command_beep,
    output logic      [3:0]  o_learn_beeps,
    output logic             o_exit_beep,
    output logic             o_save_keys
);
    import lrkcm_pkg::*;

    logic [15:0]       r_timeout;
    logic [6:0]        r_step;
    t_mode             r_mode;
    logic [SLOT_W-1:0] r_slot;
    logic [31:0]       r_last;
    logic [31:0]       r_key_table [NUM_KEYS];
    logic [7:0]        r_left_set;
    logic [7:0]        r_right_set;
    logic              r_valid;

    logic              accept;
    logic              cfg_wr;

    t_mode             mode_a;
    logic [SLOT_W-1:0] slot_a;
    logic [31:0]       last_a;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    t_key_act          act;
    logic [8:0]        up_l;
    logic [8:0]        up_r;
    logic              up_ok;
    logic              dn_ok;
    logic              learn_wr;
    logic [31:0]       idle_ms;

    t_mode             n_mode;
    logic [SLOT_W-1:0] n_slot;
    logic [31:0]       n_last;
    logic [7:0]        n_left_set;
    logic [7:0]        n_right_set;
    t_motor_cmd        n_motor_cmd;
    logic              n_left_forward;
    logic [7:0]        n_left_speed;
    logic              n_right_forward;
    logic [7:0]        n_right_speed;
    logic              n_command_beep;
    logic [3:0]        n_learn_beeps;
    logic              n_exit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign o_stall = r_valid & i_stall;
    assign accept  = i_valid & ~o_stall;
    assign o_valid = r_valid;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_TIMEOUT: prdata = {16'b0, r_timeout};
            REG_STEP:    prdata = {25'b0, r_step};
            default:     prdata = '0;
        endcase
    end

    // priority match, slot 0 wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (r_key_table[i] == i_key_code) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        mode_a = i_config_pin ? MODE_LEARN : r_mode;
        slot_a = i_config_pin ? '0 : r_slot;
        last_a = i_config_pin ? i_now_ms : r_last;

        act = KEY_NONE;
        if (i_code_valid && mode_a != MODE_LEARN && hit && hit_idx < IDX_W'(KEY_ACTIONS)) begin
            act = t_key_act'(4'(hit_idx));
        end

        up_l  = {1'b0, r_left_set} + {2'b0, r_step};
        up_r  = {1'b0, r_right_set} + {2'b0, r_step};
        up_ok = ~up_l[8] & ~up_r[8];
        dn_ok = (r_left_set >= {1'b0, r_step}) && (r_right_set >= {1'b0, r_step});

        n_mode          = mode_a;
        n_slot          = slot_a;
        n_last          = last_a;
        n_left_set      = r_left_set;
        n_right_set     = r_right_set;
        n_motor_cmd     = MOTOR_NONE;
        n_left_forward  = 1'b0;
        n_left_speed    = '0;
        n_right_forward = 1'b0;
        n_right_speed   = '0;
        n_command_beep  = 1'b0;
        n_learn_beeps   = '0;
        n_exit          = 1'b0;
        learn_wr        = 1'b0;
        idle_ms         = i_now_ms - last_a;

        unique case (act)
            KEY_STOP: begin
                n_motor_cmd     = MOTOR_DRIVE;
                n_right_forward = 1'b1;
                n_mode          = MODE_MANUAL;
            end
            KEY_FORWARD, KEY_BACKWARD, KEY_LEFT, KEY_RIGHT: begin
                n_motor_cmd     = MOTOR_DRIVE;
                n_left_forward  = (act == KEY_FORWARD) || (act == KEY_RIGHT);
                n_right_forward = (act == KEY_FORWARD) || (act == KEY_LEFT);
                n_left_speed    = r_left_set;
                n_right_speed   = r_right_set;
                n_mode          = MODE_MANUAL;
            end
            KEY_FASTER: begin
                if (up_ok) begin
                    n_left_set    = up_l[7:0];
                    n_right_set   = up_r[7:0];
                    n_motor_cmd   = MOTOR_SPEED;
                    n_left_speed  = up_l[7:0];
                    n_right_speed = up_r[7:0];
                end
                n_mode = MODE_MANUAL;
            end
            KEY_SLOWER: begin
                if (dn_ok) begin
                    n_left_set    = r_left_set - {1'b0, r_step};
                    n_right_set   = r_right_set - {1'b0, r_step};
                    n_motor_cmd   = MOTOR_SPEED;
                    n_left_speed  = r_left_set - {1'b0, r_step};
                    n_right_speed = r_right_set - {1'b0, r_step};
                end
                n_mode = MODE_MANUAL;
            end
            KEY_BEEP:  n_command_beep = 1'b1;
            KEY_AVOID: n_mode = MODE_AVOID;
            default:   ;
        endcase

        if (mode_a == MODE_LEARN) begin
            if (i_code_valid) begin
                if (slot_a < SLOT_W'(NUM_KEYS)) begin
                    learn_wr      = 1'b1;
                    n_slot        = slot_a + 1'b1;
                    n_learn_beeps = (slot_a >= SLOT_W'(BEEPS_MAX)) ? BEEPS_MAX
                                                                   : 4'(slot_a + 1'b1);
                end
                n_last = i_now_ms;
            end else if (idle_ms > {16'b0, r_timeout}) begin
                n_exit = 1'b1;
                n_mode = MODE_MANUAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= LEARN_TIMEOUT_RST;
            r_step      <= SPEED_STEP_RST;
            r_mode      <= MODE_MANUAL;
            r_slot      <= '0;
            r_last      <= '0;
            r_left_set  <= LEFT_SPEED_RST;
            r_right_set <= RIGHT_SPEED_RST;
            r_valid     <= 1'b0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_key_table[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_TIMEOUT: r_timeout <= pwdata[15:0];
                    REG_STEP:    r_step    <= pwdata[6:0];
                    default:     ;
                endcase
            end
            r_valid <= accept | (r_valid & i_stall);
            if (accept) begin
                r_mode      <= n_mode;
                r_slot      <= n_slot;
                r_last      <= n_last;
                r_left_set  <= n_left_set;
                r_right_set <= n_right_set;
                if (learn_wr) begin
                    r_key_table[slot_a[IDX_W-1:0]] <= i_key_code;
                end
            end
        end
    end

    // result register, payload only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_mode          <= n_mode;
            o_motor_cmd     <= n_motor_cmd;
            o_left_forward  <= n_left_forward;
            o_left_speed    <= n_left_speed;
            o_right_forward <= n_right_forward;
            o_right_speed   <= n_right_speed;
            o_entry_beep    <= i_config_pin;
            o_command_beep  <= n_command_beep;
            o_learn_beeps   <= n_learn_beeps;
            o_exit_beep     <= n_exit;
            o_save_keys     <= n_exit;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lrkcm_checker.sv
// Port-level checker for the mapper and its bind.
`default_nettype none

`include "learnable_remote_key_command_mapper_unit_macros.svh"

module lrkcm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [1:0] o_mode,
    input wire logic [1:0] o_motor_cmd,
    input wire logic [7:0] o_left_speed,
    input wire logic [7:0] o_right_speed,
    input wire logic [3:0] o_learn_beeps,
    input wire logic       o_exit_beep,
    input wire logic       o_save_keys
);
    import lrkcm_pkg::*;

    // held result beat keeps its payload
    `LRKCM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_mode) && $stable(o_motor_cmd) && $stable(o_learn_beeps))

    // leaving learn mode always saves and lands in manual
    `LRKCM_ASSERT_IMP(a_exit, i_clk, i_rst_n, o_valid && o_exit_beep, o_save_keys && o_mode == MODE_MANUAL)

    // confirmation beeps only while still learning
    `LRKCM_ASSERT_IMP(a_beeps, i_clk, i_rst_n, o_valid && o_learn_beeps != 4'd0, o_mode == MODE_LEARN && !o_exit_beep)

    // no motor update carries no speed
    `LRKCM_ASSERT_IMP(a_idle, i_clk, i_rst_n, o_valid && o_motor_cmd == MOTOR_NONE, o_left_speed == 8'd0 && o_right_speed == 8'd0)

endmodule

bind learnable_remote_key_command_mapper_unit lrkcm_checker u_lrkcm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_mode        (o_mode),
    .o_motor_cmd   (o_motor_cmd),
    .o_left_speed  (o_left_speed),
    .o_right_speed (o_right_speed),
    .o_learn_beeps (o_learn_beeps),
    .o_exit_beep   (o_exit_beep),
    .o_save_keys   (o_save_keys)
);

`default_nettype wire
